// ===== rtl/pbmd_pkg.sv =====
// ---------------------------------------------------------------------------
// pbmd_pkg
// Shared types and constants of the balance controller and bridge drive.
// ---------------------------------------------------------------------------
`default_nettype none

package pbmd_pkg;

   localparam int ANGLE_W  = 16;
   localparam int PID_W    = 17;
   localparam int DUTY_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int I_LIMIT   = 6400;
   localparam int D_LIMIT   = 65280;
   localparam int OUT_LIMIT = 65280;
   localparam int DUTY_MAX  = 255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT     = 3'd0,
      CSR_KP           = 3'd1,
      CSR_KI_DT        = 3'd2,
      CSR_KD_DIV_DT    = 3'd3,
      CSR_MOTOR_OFFSET = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] kp;
      logic signed [15:0] ki_dt;
      logic signed [23:0] kd_div_dt;
      logic        [7:0]  motor_offset;
   } pbmd_cfg_type;

   typedef struct packed {
      logic load_s0;
      logic load_s1;
      logic load_out;
   } pbmd_ctrl_type;

   typedef struct packed {
      logic signed [PID_W-1:0] pid_value;
      logic [DUTY_W-1:0]       right_in1_duty;
      logic [DUTY_W-1:0]       right_in2_duty;
      logic [DUTY_W-1:0]       left_in1_duty;
      logic [DUTY_W-1:0]       left_in2_duty;
   } pbmd_result_type;

endpackage

`default_nettype wire

// ===== rtl/pbmd_req_if.sv =====
// ---------------------------------------------------------------------------
// pbmd_req_if
// Angle sample channel: valid, ready and one roll angle.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbmd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;

   modport source (output valid, output roll_angle, input ready);
   modport sink   (input valid, input roll_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/pbmd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// pbmd_rsp_if
// Result channel: controller output and the four bridge duties.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbmd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] pid_value;
   logic [7:0]         right_in1_duty;
   logic [7:0]         right_in2_duty;
   logic [7:0]         left_in1_duty;
   logic [7:0]         left_in2_duty;

   modport source (output valid, output pid_value, output right_in1_duty,
                   output right_in2_duty, output left_in1_duty,
                   output left_in2_duty, input ready);
   modport sink   (input valid, input pid_value, input right_in1_duty,
                   input right_in2_duty, input left_in1_duty,
                   input left_in2_duty, output ready);
endinterface

`default_nettype wire

// ===== rtl/pbmd_csr_if.sv =====
// ---------------------------------------------------------------------------
// pbmd_csr_if
// Register write channel: valid, ready, register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbmd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pbmd_core.sv =====
// ---------------------------------------------------------------------------
// pbmd_core
// Three-stage PID datapath: angle register, product register, result
// register, with the integral and last-error state.
// ---------------------------------------------------------------------------
`default_nettype none

module pbmd_core
   import pbmd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pbmd_ctrl_type      ctrl,
   input  wire pbmd_cfg_type       cfg,
   input  wire logic signed [15:0] roll_angle,
   output pbmd_result_type         result
);

   logic signed [15:0] angle_ff;

   logic signed [16:0] err;
   logic signed [17:0] derr;
   logic signed [32:0] p_prod_ff, p_prod_in;
   logic signed [32:0] i_prod_ff, i_prod_in;
   logic signed [41:0] d_prod_ff, d_prod_in;
   logic signed [16:0] last_error_ff;

   logic signed [13:0] integral_ff, integral_in;
   logic signed [24:0] p_term;
   logic signed [24:0] i_step;
   logic signed [25:0] i_sum;
   logic signed [33:0] d_full;
   logic signed [16:0] d_term;
   logic signed [26:0] pid_sum;
   logic signed [16:0] pid;
   logic signed [16:0] pid_abs;
   logic [15:0]        mag;
   logic [8:0]         duty_sum;
   logic [7:0]         duty;
   pbmd_result_type    result_ff, result_in;

   // stage one: error, error step and products
   always_comb begin
      err       = 17'(cfg.setpoint) - 17'(angle_ff);
      derr      = 18'(err) - 18'(last_error_ff);
      p_prod_in = 33'(cfg.kp) * 33'(err);
      i_prod_in = 33'(cfg.ki_dt) * 33'(err);
      d_prod_in = 42'(cfg.kd_div_dt) * 42'(derr);
   end

   // stage two: floor shifts, integral, clamps, bridge selection
   always_comb begin
      p_term = 25'(p_prod_ff >>> 8);
      i_step = 25'(i_prod_ff >>> 8);
      i_sum  = 26'(integral_ff) + 26'(i_step);
      if (i_sum > I_LIMIT) begin
         integral_in = 14'(I_LIMIT);
      end else if (i_sum < -I_LIMIT) begin
         integral_in = 14'(-I_LIMIT);
      end else begin
         integral_in = 14'(i_sum);
      end

      d_full = 34'(d_prod_ff >>> 8);
      if (d_full > D_LIMIT) begin
         d_term = 17'(D_LIMIT);
      end else if (d_full < -D_LIMIT) begin
         d_term = 17'(-D_LIMIT);
      end else begin
         d_term = 17'(d_full);
      end

      pid_sum = 27'(p_term) + 27'(integral_in) + 27'(d_term);
      if (pid_sum > OUT_LIMIT) begin
         pid = 17'(OUT_LIMIT);
      end else if (pid_sum < -OUT_LIMIT) begin
         pid = 17'(-OUT_LIMIT);
      end else begin
         pid = 17'(pid_sum);
      end

      pid_abs  = pid[16] ? -pid : pid;
      mag      = pid_abs[15:0];
      duty_sum = 9'(mag[15:8]) + 9'(cfg.motor_offset);
      duty     = (duty_sum > 9'(DUTY_MAX)) ? 8'(DUTY_MAX) : duty_sum[7:0];

      result_in.pid_value = pid;
      if (pid > 17'sd0) begin
         result_in.right_in1_duty = duty;
         result_in.right_in2_duty = '0;
         result_in.left_in1_duty  = '0;
         result_in.left_in2_duty  = duty;
      end else begin
         result_in.right_in1_duty = '0;
         result_in.right_in2_duty = duty;
         result_in.left_in1_duty  = duty;
         result_in.left_in2_duty  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s0) begin
         angle_ff <= roll_angle;
      end
      if (ctrl.load_s1) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
      if (ctrl.load_out) begin
         result_ff <= result_in;
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         if (ctrl.load_s1) begin
            last_error_ff <= err;
         end
         if (ctrl.load_out) begin
            integral_ff <= integral_in;
         end
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/pid_balance_motor_drive_top.sv =====
// ---------------------------------------------------------------------------
// pid_balance_motor_drive_top
// PID balance controller with clamped integral and H-bridge duty drive.
// ---------------------------------------------------------------------------
// path: an accepted sample passes the angle, product and result registers
//   before its result is offered; any of them can hold under a stall
// throughput: one sample per cycle while results are taken, set by the integral
//   update in the second stage; each stage holds while the one after it is full
// reset: synchronous; clears the configuration registers, valid bits,
//   integral and last error
`default_nettype none

module pid_balance_motor_drive_top
   import pbmd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pbmd_req_if.sink   req_chan,
   pbmd_rsp_if.source rsp_chan,
   pbmd_csr_if.sink   csr_chan
);

   pbmd_cfg_type    cfg_ff;
   pbmd_ctrl_type   ctrl;
   pbmd_result_type result;

   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic ready_out;
   logic ready_s1;
   logic ready_s0;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_SETPOINT:     cfg_ff.setpoint     <= csr_chan.data[15:0];
            CSR_KP:           cfg_ff.kp           <= csr_chan.data[15:0];
            CSR_KI_DT:        cfg_ff.ki_dt        <= csr_chan.data[15:0];
            CSR_KD_DIV_DT:    cfg_ff.kd_div_dt    <= csr_chan.data;
            CSR_MOTOR_OFFSET: cfg_ff.motor_offset <= csr_chan.data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ready_out     = !out_valid_ff || rsp_chan.ready;
      ready_s1      = !s1_valid_ff || ready_out;
      ready_s0      = !s0_valid_ff || ready_s1;
      ctrl.load_out = s1_valid_ff && ready_out;
      ctrl.load_s1  = s0_valid_ff && ready_s1;
      ctrl.load_s0  = req_chan.valid && ready_s0;

      s0_valid_in  = ctrl.load_s0 || (s0_valid_ff && !ctrl.load_s1);
      s1_valid_in  = ctrl.load_s1 || (s1_valid_ff && !ctrl.load_out);
      out_valid_in = ctrl.load_out || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   pbmd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cfg        (cfg_ff),
      .roll_angle (req_chan.roll_angle),
      .result     (result)
   );

   assign req_chan.ready          = ready_s0;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.pid_value      = result.pid_value;
   assign rsp_chan.right_in1_duty = result.right_in1_duty;
   assign rsp_chan.right_in2_duty = result.right_in2_duty;
   assign rsp_chan.left_in1_duty  = result.left_in1_duty;
   assign rsp_chan.left_in2_duty  = result.left_in2_duty;

   a_accept_fills_s0: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s0_valid_ff)
      else $error("accepted sample did not reach the angle stage");

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |=> s1_valid_ff)
      else $error("product stage dropped an item under stall");

   a_pid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pid_value <= 17'sd65280 &&
                          rsp_chan.pid_value >= -17'sd65280))
      else $error("pid value outside clamp range");

   a_diag_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.right_in1_duty == rsp_chan.left_in2_duty &&
                          rsp_chan.right_in2_duty == rsp_chan.left_in1_duty))
      else $error("bridge diagonal duties differ");

   a_positive_side: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pid_value > 17'sd0) |->
         (rsp_chan.right_in2_duty == 8'd0 && rsp_chan.left_in1_duty == 8'd0))
      else $error("positive output drives the reverse pair");

endmodule

`default_nettype wire

// ===== test/pid_balance_motor_drive_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_balance_motor_drive_top_test
// Self-checking bench for the balance controller and bridge drive. A short
// table of register writes and angle samples covers the reset state, gain
// and angle extremes, integral and derivative saturation and the sign split
// of the bridge duties. Random gain settings and angle streams follow. Each
// result is checked field by field against its table value or an in-bench
// fixed-point predictor, with random gaps and stalls on both handshake sides.
// ---------------------------------------------------------------------------

module pid_balance_motor_drive_top_test
   import pbmd_pkg::*;
();

   localparam int RANDOM_ITEMS = 950;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   typedef enum bit {ROW_CSR, ROW_ANGLE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic signed [15:0]    angle;
      bit                    typed;
      pbmd_result_type       want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   pbmd_req_if req_bus ();
   pbmd_rsp_if rsp_bus ();
   pbmd_csr_if csr_bus ();

   pid_balance_motor_drive_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // controller settings and loop state as the bench sees them
   logic signed [15:0] set_angle = '0;
   logic signed [15:0] gain_p = '0;
   logic signed [15:0] gain_i = '0;
   logic signed [23:0] gain_d = '0;
   logic        [7:0]  duty_offset = '0;
   logic signed [13:0] integral_acc = '0;
   logic signed [16:0] err_history = '0;

   pbmd_result_type pending_results[$];
   int mismatch_count = 0;
   bit sender_burst = 1'b0;
   bit receiver_burst = 1'b0;

   function automatic longint limit_to(longint v, longint lim);
      if (v < -lim)
         return -lim;
      if (v > lim)
         return lim;
      return v;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SETPOINT:     set_angle = value[15:0];
         CSR_KP:           gain_p = value[15:0];
         CSR_KI_DT:        gain_i = value[15:0];
         CSR_KD_DIV_DT:    gain_d = value[23:0];
         CSR_MOTOR_OFFSET: duty_offset = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic pbmd_result_type predict_drive(logic signed [15:0] angle);
      longint err, p, i_sum, d, pid, mag, duty;
      pbmd_result_type res;
      err = longint'(set_angle) - longint'(angle);
      p = (longint'(gain_p) * err) >>> 8;
      i_sum = limit_to(longint'(integral_acc) + ((longint'(gain_i) * err) >>> 8), I_LIMIT);
      integral_acc = i_sum[13:0];
      d = limit_to((longint'(gain_d) * (err - longint'(err_history))) >>> 8, D_LIMIT);
      err_history = err[16:0];
      pid = limit_to(p + i_sum + d, OUT_LIMIT);
      mag = (pid < 0) ? -pid : pid;
      duty = (mag >>> 8) + longint'(duty_offset);
      if (duty > DUTY_MAX)
         duty = DUTY_MAX;
      res = '0;
      res.pid_value = pid[16:0];
      if (pid > 0) begin
         res.right_in1_duty = duty[7:0];
         res.left_in2_duty = duty[7:0];
      end else begin
         res.right_in2_duty = duty[7:0];
         res.left_in1_duty = duty[7:0];
      end
      return res;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, int value);
      stim_row_type row;
      row = '{kind: ROW_CSR, index: idx, data: value[23:0], angle: '0, typed: 1'b0,
              want: '0};
      return row;
   endfunction

   function automatic stim_row_type angle_row(int angle, bit typed = 1'b0, int pid = 0,
                                              int r1 = 0, int r2 = 0, int l1 = 0,
                                              int l2 = 0);
      stim_row_type row;
      row.kind = ROW_ANGLE;
      row.index = '0;
      row.data = '0;
      row.angle = angle[15:0];
      row.typed = typed;
      row.want.pid_value = pid[16:0];
      row.want.right_in1_duty = r1[7:0];
      row.want.right_in2_duty = r2[7:0];
      row.want.left_in1_duty = l1[7:0];
      row.want.left_in2_duty = l2[7:0];
      return row;
   endfunction

   function automatic int pick_signed(int width, int span);
      case ($urandom_range(0, 5))
         0: return -(1 << (width - 1));
         1: return (1 << (width - 1)) - 1;
         2, 3: return int'($urandom_range(0, 2 * span)) - span;
         default: return int'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, field, got, want);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      apply_csr(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_angle(logic signed [15:0] angle, bit typed, pbmd_result_type want);
      int gap;
      pbmd_result_type predicted;
      if ($urandom_range(0, 31) == 0)
         sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.roll_angle <= angle;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = predict_drive(angle);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // result side: random stalls, then check each transfer
   initial begin
      int stall;
      pbmd_result_type want;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 31) == 0)
            receiver_burst = !receiver_burst;
         stall = receiver_burst ? 0 : $urandom_range(0, 5);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result pid_value", rsp_bus.pid_value, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.pid_value !== want.pid_value)
               report_mismatch("pid_value", rsp_bus.pid_value, want.pid_value);
            if (rsp_bus.right_in1_duty !== want.right_in1_duty)
               report_mismatch("right_in1_duty", rsp_bus.right_in1_duty, want.right_in1_duty);
            if (rsp_bus.right_in2_duty !== want.right_in2_duty)
               report_mismatch("right_in2_duty", rsp_bus.right_in2_duty, want.right_in2_duty);
            if (rsp_bus.left_in1_duty !== want.left_in1_duty)
               report_mismatch("left_in1_duty", rsp_bus.left_in1_duty, want.left_in1_duty);
            if (rsp_bus.left_in2_duty !== want.left_in2_duty)
               report_mismatch("left_in2_duty", rsp_bus.left_in2_duty, want.left_in2_duty);
         end
      end
   end

   initial begin
      stim_row_type directed[$];
      int sent;
      int delta;
      int span;
      logic [CSR_DATA_W-1:0] csr_value;
      logic signed [15:0] angle;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.roll_angle = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all gains zero after reset
      directed.push_back(angle_row(0, 1'b1, 0));
      directed.push_back(angle_row(32767, 1'b1, 0));
      directed.push_back(angle_row(-32768, 1'b1, 0));
      // unit proportional gain, both signs
      directed.push_back(csr_row(CSR_KP, 'h0100));
      directed.push_back(angle_row(-256, 1'b1, 256, 1, 0, 0, 1));
      directed.push_back(angle_row(256, 1'b1, -256, 0, 1, 1, 0));
      directed.push_back(angle_row(0, 1'b1, 0));
      // output saturation at both gain extremes
      directed.push_back(csr_row(CSR_KP, 'h7FFF));
      directed.push_back(angle_row(-32768, 1'b1, OUT_LIMIT, 255, 0, 0, 255));
      directed.push_back(angle_row(32767, 1'b1, -OUT_LIMIT, 0, 255, 255, 0));
      directed.push_back(csr_row(CSR_KP, 'h8000));
      directed.push_back(angle_row(-32768, 1'b1, -OUT_LIMIT, 0, 255, 255, 0));
      // zero output drives right_in2 and left_in1 with the offset alone
      directed.push_back(csr_row(CSR_MOTOR_OFFSET, 'hFF));
      directed.push_back(angle_row(0, 1'b1, 0, 0, 255, 255, 0));
      directed.push_back(csr_row(CSR_KP, 0));
      directed.push_back(csr_row(CSR_SETPOINT, 'h7FFF));
      directed.push_back(angle_row(-32768, 1'b1, 0, 0, 255, 255, 0));
      // integral clamp in both directions
      directed.push_back(csr_row(CSR_SETPOINT, 0));
      directed.push_back(csr_row(CSR_MOTOR_OFFSET, 0));
      directed.push_back(csr_row(CSR_KI_DT, 'h7FFF));
      directed.push_back(angle_row(-32768, 1'b1, I_LIMIT, 25, 0, 0, 25));
      directed.push_back(angle_row(-32768, 1'b1, I_LIMIT, 25, 0, 0, 25));
      directed.push_back(angle_row(32767, 1'b1, -I_LIMIT, 0, 25, 25, 0));
      // derivative extremes, ignored index, duty overflow
      directed.push_back(csr_row(CSR_KI_DT, 0));
      directed.push_back(csr_row(CSR_KD_DIV_DT, 'h7FFFFF));
      directed.push_back(angle_row(0));
      directed.push_back(angle_row(-32768));
      directed.push_back(csr_row(CSR_KD_DIV_DT, 'h800000));
      directed.push_back(angle_row(32767));
      directed.push_back(angle_row(0));
      directed.push_back(csr_row(CSR_SPARE_LAST, 'hFFFFFF));
      directed.push_back(csr_row(CSR_MOTOR_OFFSET, 200));
      directed.push_back(csr_row(CSR_KD_DIV_DT, 'h000100));
      directed.push_back(angle_row(-1000));
      directed.push_back(csr_row(CSR_KI_DT, 'hFF80));
      directed.push_back(angle_row(5000));
      directed.push_back(angle_row(-5000));
      directed.push_back(csr_row(CSR_SETPOINT, 'h8000));
      directed.push_back(angle_row(32767));

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed[i].index, directed[i].data);
         end else begin
            send_angle(directed[i].angle, directed[i].typed, directed[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         // unused upper data bits carry noise
         if ($urandom_range(0, 3) != 0) begin
            csr_value = 24'($urandom);
            csr_value[15:0] = 16'(pick_signed(16, 4096));
            write_csr(CSR_SETPOINT, csr_value);
         end
         if ($urandom_range(0, 3) != 0) begin
            csr_value = 24'($urandom);
            csr_value[15:0] = 16'(pick_signed(16, 1024));
            write_csr(CSR_KP, csr_value);
         end
         if ($urandom_range(0, 3) != 0) begin
            csr_value = 24'($urandom);
            csr_value[15:0] = 16'(pick_signed(16, 128));
            write_csr(CSR_KI_DT, csr_value);
         end
         if ($urandom_range(0, 3) != 0)
            write_csr(CSR_KD_DIV_DT, 24'(pick_signed(24, 2048)));
         if ($urandom_range(0, 3) != 0) begin
            csr_value = 24'($urandom);
            case ($urandom_range(0, 3))
               0: csr_value[7:0] = 8'd0;
               1: csr_value[7:0] = 8'd255;
               default: ;
            endcase
            write_csr(CSR_MOTOR_OFFSET, csr_value);
         end
         if ($urandom_range(0, 3) == 0)
            write_csr(3'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), 24'($urandom));

         repeat ($urandom_range(30, 100)) begin
            if ($urandom_range(0, 63) == 0)
               wait_idle();
            if ($urandom_range(0, 3) == 0) begin
               angle = 16'($urandom);
            end else begin
               span = $urandom_range(0, 1) ? 256 : 4096;
               delta = int'($urandom_range(0, 2 * span)) - span;
               angle = 16'(int'(set_angle) + delta);
            end
            send_angle(angle, 1'b0, '0);
            sent++;
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
